// ===== sv/block_transfer_address_sequencer_assert.svh =====
// Assertion macros for the block transfer address sequencer
`ifndef BLOCK_TRANSFER_ADDRESS_SEQUENCER_ASSERT_SVH
`define BLOCK_TRANSFER_ADDRESS_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BTAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btas assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BTAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btas assertion failed");

`endif

// ===== sv/btas_pkg.sv =====
// Types and constants shared by the block transfer address sequencer
`default_nettype none
package btas_pkg;

  localparam int unsigned LIST_W  = 16;
  localparam int unsigned REG_W   = 4;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 5;
  localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;

  typedef struct packed {
    logic              pre_index;
    logic              go_up;
    logic              user_bank;
    logic              write_back;
    logic              is_load;
    logic [REG_W-1:0]  base_reg;
    logic [LIST_W-1:0] register_list;
    logic [ADDR_W-1:0] base_value;
  } btas_in_t;

  typedef struct packed {
    logic              access_valid;
    logic              access_load;
    logic [REG_W-1:0]  access_reg;
    logic [ADDR_W-1:0] access_address;
    logic              writeback_enable;
    logic [REG_W-1:0]  writeback_reg;
    logic [ADDR_W-1:0] writeback_value;
    logic              last;
  } btas_out_t;

  // classified instruction handed from front to back
  typedef struct packed {
    logic              load;
    logic [LIST_W-1:0] list;
    logic [ADDR_W-1:0] start_addr;
    logic              wb_en;
    logic [REG_W-1:0]  wb_reg;
    logic [ADDR_W-1:0] wb_value;
  } btas_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } btas_qctl_t;

endpackage
`default_nettype wire

// ===== sv/btas_front.sv =====
// Front end: accepts instructions, counts registers and computes addresses
`default_nettype none
module btas_front #(
  parameter int REGISTER_COUNT = 16
) (
  input  logic                in_valid,
  input  btas_pkg::btas_in_t  in_data,
  output logic                in_stall,
  input  logic                q_full,
  output logic                q_push,
  output btas_pkg::btas_cmd_t q_cmd
);
  import btas_pkg::*;

  localparam logic [LIST_W-1:0] LIST_MASK = LIST_W'((33'd1 << REGISTER_COUNT) - 33'd1);

  function automatic logic [2:0] nib_count(input logic [3:0] v);
    logic [2:0] c;
    c = 3'd0;
    for (int i = 0; i < 4; i++) c = c + 3'(v[i]);
    return c;
  endfunction

  logic [LIST_W-1:0]  list;
  logic [COUNT_W-1:0] count;
  logic [6:0]         off4n;
  logic [6:0]         dn_off;
  logic [ADDR_W-1:0]  base;

  assign list  = in_data.register_list & LIST_MASK;
  assign count = COUNT_W'(nib_count(list[3:0])) + COUNT_W'(nib_count(list[7:4]))
               + COUNT_W'(nib_count(list[11:8])) + COUNT_W'(nib_count(list[15:12]));
  assign off4n  = {count, 2'b00};
  assign dn_off = in_data.pre_index ? off4n : off4n - 7'd4;
  assign base   = in_data.base_value;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.load   = in_data.is_load;
    q_cmd.list   = list;
    q_cmd.wb_en  = in_data.write_back && !in_data.user_bank;
    q_cmd.wb_reg = in_data.base_reg;
    if (in_data.go_up) begin
      q_cmd.wb_value   = base + {25'd0, off4n};
      q_cmd.start_addr = in_data.pre_index ? base + WORD_BYTES : base;
    end else begin
      q_cmd.wb_value   = base - {25'd0, off4n};
      // start address is unused for an empty list
      q_cmd.start_addr = base - {25'd0, dn_off};
    end
  end

endmodule
`default_nettype wire

// ===== sv/btas_queue.sv =====
// Two-entry queue between front and back
`default_nettype none
module btas_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  btas_pkg::btas_qctl_t ctl_in,
  output btas_pkg::btas_qctl_t ctl_out,
  input  btas_pkg::btas_cmd_t wr_cmd,
  output btas_pkg::btas_cmd_t rd_cmd
);
  import btas_pkg::*;

  btas_cmd_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign ctl_out.full  = (cnt_r == 2'd2);
  assign ctl_out.empty = (cnt_r == 2'd0);
  assign ctl_out.push  = do_push;
  assign ctl_out.pop   = do_pop;
  assign do_push = ctl_in.push && !ctl_out.full;
  assign do_pop  = ctl_in.pop && !ctl_out.empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/btas_back.sv =====
// Back end: walks the register list and issues one result per cycle unless the output stalls
`default_nettype none
module btas_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  btas_pkg::btas_cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output btas_pkg::btas_out_t out_data
);
  import btas_pkg::*;

  function automatic logic [REG_W-1:0] onehot_idx(input logic [LIST_W-1:0] v);
    logic [REG_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < LIST_W; i++) begin
      if (v[i]) idx = idx | REG_W'(i);
    end
    return idx;
  endfunction

  logic              busy_r, busy_nxt;
  btas_cmd_t         cmd_r, cmd_nxt;
  logic              out_valid_r, out_valid_nxt;
  btas_out_t         out_data_r, out_data_nxt;
  logic              out_free, emit, is_last, load_ok;
  logic [LIST_W-1:0] lowest, rest;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = busy_r && out_free;
  assign lowest   = cmd_r.list & (~cmd_r.list + LIST_W'(1));
  assign rest     = cmd_r.list & ~lowest;
  assign is_last  = (rest == '0);
  assign load_ok  = !busy_r || (emit && is_last);
  assign q_pop    = load_ok && !q_empty;

  always_comb begin
    busy_nxt      = busy_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (cmd_r.list != '0) begin
        out_data_nxt.access_valid   = 1'b1;
        out_data_nxt.access_load    = cmd_r.load;
        out_data_nxt.access_reg     = onehot_idx(lowest);
        out_data_nxt.access_address = cmd_r.start_addr;
      end
      if (is_last) begin
        out_data_nxt.writeback_enable = cmd_r.wb_en;
        out_data_nxt.writeback_reg    = cmd_r.wb_reg;
        out_data_nxt.writeback_value  = cmd_r.wb_value;
        out_data_nxt.last             = 1'b1;
        busy_nxt                      = 1'b0;
      end
      cmd_nxt.list       = rest;
      cmd_nxt.start_addr = cmd_r.start_addr + WORD_BYTES;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      cmd_nxt  = q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== sv/block_transfer_address_sequencer.sv =====
// Top level of the block transfer address sequencer
// Expands one block load/store instruction into word accesses, lowest register at
// the lowest address, one result per set list bit (one result with no access for
// an empty list); the last result carries the base writeback. The back end issues
// one result per cycle from its list walker unless the output stalls; an
// instruction with n registers yields max(n,1) results, and a queued instruction
// follows the previous one with no gap. A two-entry queue decouples instruction
// intake from issue via a queue entry, the command register and output register.
// List bits at or above REGISTER_COUNT are ignored.
`default_nettype none
`include "block_transfer_address_sequencer_assert.svh"
module block_transfer_address_sequencer #(
  parameter int REGISTER_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  btas_pkg::btas_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output btas_pkg::btas_out_t out_data
);
  import btas_pkg::*;

  btas_cmd_t  front_cmd, back_cmd;
  btas_qctl_t q_req, q_stat;
  logic       front_push, back_pop;

  btas_front #(.REGISTER_COUNT(REGISTER_COUNT)) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_stat.full),
    .q_push   (front_push),
    .q_cmd    (front_cmd)
  );

  always_comb begin
    q_req       = '0;
    q_req.push  = front_push;
    q_req.pop   = back_pop;
  end

  btas_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (q_req),
    .ctl_out (q_stat),
    .wr_cmd  (front_cmd),
    .rd_cmd  (back_cmd)
  );

  btas_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_stat.empty),
    .q_cmd     (back_cmd),
    .q_pop     (back_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `BTAS_ASSERT_NOW(a_wb_only_last, out_valid && !out_data.last, !out_data.writeback_enable)
  `BTAS_ASSERT_NOW(a_empty_is_last, out_valid && !out_data.access_valid, out_data.last)
  `BTAS_ASSERT_NOW(a_reg_in_range, out_valid && out_data.access_valid, 32'(out_data.access_reg) < 32'(REGISTER_COUNT))
  `BTAS_ASSERT_NEXT(a_burst_no_gap, out_valid && !out_stall && !out_data.last, out_valid)

endmodule
`default_nettype wire

// ===== bench/tb_block_transfer_address_sequencer.sv =====
// Testbench for the block transfer address sequencer: directed table, then random items
`timescale 1ns / 100ps
module tb_block_transfer_address_sequencer;
  import btas_pkg::*;

  localparam int REG_COUNT = 16;

  typedef struct {
    btas_in_t  stim;
    bit        typed;
    btas_out_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  btas_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  btas_out_t out_data;

  btas_out_t pending_accesses[$];
  dir_row_t  dir_rows[$];
  btas_out_t exp_item;
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;

  block_transfer_address_sequencer #(
    .REGISTER_COUNT(REG_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  function automatic btas_in_t make_instr(input bit p, input bit u, input bit s, input bit w,
                                          input bit l, input logic [3:0] rn,
                                          input logic [15:0] list, input logic [31:0] base);
    btas_in_t x;
    x.pre_index     = p;
    x.go_up         = u;
    x.user_bank     = s;
    x.write_back    = w;
    x.is_load       = l;
    x.base_reg      = rn;
    x.register_list = list;
    x.base_value    = base;
    return x;
  endfunction

  function automatic btas_out_t make_result(input bit v, input bit l, input logic [3:0] r,
                                            input logic [31:0] addr, input bit wben,
                                            input logic [3:0] wbreg,
                                            input logic [31:0] wbval, input bit fin);
    btas_out_t x;
    x.access_valid     = v;
    x.access_load      = l;
    x.access_reg       = r;
    x.access_address   = addr;
    x.writeback_enable = wben;
    x.writeback_reg    = wbreg;
    x.writeback_value  = wbval;
    x.last             = fin;
    return x;
  endfunction

  task automatic add_row(input btas_in_t stim, input bit typed, input btas_out_t want);
    dir_row_t row;
    row.stim  = stim;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // lowest register at lowest address; last access carries the writeback
  function automatic void expand_block_transfer(input btas_in_t ins);
    logic [31:0] n;
    logic [31:0] wb_val;
    logic [31:0] addr;
    logic        wb_en;
    logic [31:0] emitted;
    btas_out_t   r;
    n = 0;
    for (int i = 0; i < REG_COUNT; i++) begin
      if (ins.register_list[i]) n++;
    end
    if (ins.go_up) begin
      wb_val = ins.base_value + WORD_BYTES * n;
      addr   = ins.pre_index ? ins.base_value + WORD_BYTES : ins.base_value;
    end else begin
      wb_val = ins.base_value - WORD_BYTES * n;
      addr   = ins.pre_index ? wb_val : wb_val + WORD_BYTES;
    end
    wb_en = ins.write_back & ~ins.user_bank;
    if (n == 0) begin
      pending_accesses.push_back(make_result(0, 0, 0, 0, wb_en, ins.base_reg, wb_val, 1));
    end else begin
      emitted = 0;
      for (int i = 0; i < REG_COUNT; i++) begin
        if (ins.register_list[i]) begin
          emitted++;
          if (emitted == n)
            r = make_result(1, ins.is_load, i[3:0], addr, wb_en, ins.base_reg, wb_val, 1);
          else
            r = make_result(1, ins.is_load, i[3:0], addr, 0, 0, 0, 0);
          pending_accesses.push_back(r);
          addr = addr + WORD_BYTES;
        end
      end
    end
  endfunction

  task automatic drive_item(input btas_in_t x, input bit typed, input btas_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed)
      pending_accesses.push_back(want);
    else
      expand_block_transfer(x);
  endtask

  task automatic drain_accesses();
    in_valid <= 1'b0;
    while (pending_accesses.size() != 0) @(posedge clk);
  endtask

  function automatic btas_in_t random_instr();
    logic [31:0] run;
    logic [15:0] list;
    logic [31:0] base;
    int          sel;
    sel = $urandom_range(9);
    case (sel)
      0: list = '0;
      1: list = 16'h1 << $urandom_range(15);
      2: list = 16'hffff;
      3: begin
        run  = ((32'd1 << $urandom_range(1, 16)) - 1) << $urandom_range(15);
        list = run[15:0];
      end
      default: list = 16'($urandom);
    endcase
    sel = $urandom_range(3);
    case (sel)
      0: base = $urandom_range(15) << 2;
      1: base = 32'hffff_ffc0 | $urandom_range(63);
      default: base = $urandom;
    endcase
    return make_instr(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      4'($urandom_range(15)), list, base);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_accesses.size() == 0) begin
        $error("unexpected result: %h", out_data);
        mismatches++;
      end else begin
        exp_item = pending_accesses.pop_front();
        if (out_data.access_valid !== exp_item.access_valid) begin
          $error("access_valid: expected %0h, got %0h",
                 exp_item.access_valid, out_data.access_valid);
          mismatches++;
        end
        if (out_data.access_load !== exp_item.access_load) begin
          $error("access_load: expected %0h, got %0h",
                 exp_item.access_load, out_data.access_load);
          mismatches++;
        end
        if (out_data.access_reg !== exp_item.access_reg) begin
          $error("access_reg: expected %0h, got %0h",
                 exp_item.access_reg, out_data.access_reg);
          mismatches++;
        end
        if (out_data.access_address !== exp_item.access_address) begin
          $error("access_address: expected %0h, got %0h",
                 exp_item.access_address, out_data.access_address);
          mismatches++;
        end
        if (out_data.writeback_enable !== exp_item.writeback_enable) begin
          $error("writeback_enable: expected %0h, got %0h",
                 exp_item.writeback_enable, out_data.writeback_enable);
          mismatches++;
        end
        if (out_data.writeback_reg !== exp_item.writeback_reg) begin
          $error("writeback_reg: expected %0h, got %0h",
                 exp_item.writeback_reg, out_data.writeback_reg);
          mismatches++;
        end
        if (out_data.writeback_value !== exp_item.writeback_value) begin
          $error("writeback_value: expected %0h, got %0h",
                 exp_item.writeback_value, out_data.writeback_value);
          mismatches++;
        end
        if (out_data.last !== exp_item.last) begin
          $error("last: expected %0h, got %0h", exp_item.last, out_data.last);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("tb_block_transfer_address_sequencer: done, errors");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    mismatches    = 0;
    send_idle_pct = 31;
    recv_idle_pct = 58;

    // empty lists
    add_row(make_instr(0, 1, 0, 0, 0, 0, 16'h0000, 32'h0), 1,
            make_result(0, 0, 0, 32'h0, 0, 0, 32'h0, 1));
    add_row(make_instr(1, 0, 0, 1, 1, 15, 16'h0000, 32'hffff_ffff), 1,
            make_result(0, 0, 0, 32'h0, 1, 15, 32'hffff_ffff, 1));
    add_row(make_instr(1, 1, 1, 1, 0, 5, 16'h0000, 32'h1234_5678), 1,
            make_result(0, 0, 0, 32'h0, 0, 5, 32'h1234_5678, 1));
    // one register in each addressing mode, wrap at both ends
    add_row(make_instr(0, 1, 0, 1, 1, 3, 16'h0001, 32'h0000_1000), 1,
            make_result(1, 1, 0, 32'h0000_1000, 1, 3, 32'h0000_1004, 1));
    add_row(make_instr(1, 1, 0, 1, 0, 13, 16'h8000, 32'hffff_fffc), 1,
            make_result(1, 0, 15, 32'h0, 1, 13, 32'h0, 1));
    add_row(make_instr(0, 0, 0, 1, 1, 7, 16'h0080, 32'h0), 1,
            make_result(1, 1, 7, 32'h0, 1, 7, 32'hffff_fffc, 1));
    add_row(make_instr(1, 0, 1, 1, 0, 0, 16'h0001, 32'h0), 1,
            make_result(1, 0, 0, 32'hffff_fffc, 0, 0, 32'hffff_fffc, 1));
    add_row(make_instr(1, 0, 0, 0, 1, 9, 16'h0200, 32'h0000_0100), 1,
            make_result(1, 1, 9, 32'h0000_00fc, 0, 9, 32'h0000_00fc, 1));
    // multi-register lists
    add_row(make_instr(0, 1, 0, 1, 1, 13, 16'hffff, 32'h0), 0, '0);
    add_row(make_instr(1, 1, 0, 1, 0, 2, 16'hffff, 32'hffff_fff0), 0, '0);
    add_row(make_instr(0, 0, 0, 1, 1, 11, 16'hffff, 32'h0000_0040), 0, '0);
    add_row(make_instr(1, 0, 0, 1, 0, 4, 16'hffff, 32'h0000_003c), 0, '0);
    add_row(make_instr(0, 1, 0, 1, 0, 15, 16'h5555, 32'hffff_ffff), 0, '0);
    add_row(make_instr(1, 0, 0, 0, 1, 1, 16'haaaa, 32'h8000_0000), 0, '0);
    add_row(make_instr(0, 0, 1, 1, 0, 0, 16'h8001, 32'h0000_0004), 0, '0);
    add_row(make_instr(1, 1, 0, 1, 1, 6, 16'h7ffe, 32'hffff_fff8), 0, '0);
    add_row(make_instr(1, 1, 1, 1, 1, 15, 16'hffff, 32'hffff_ffff), 0, '0);
    add_row(make_instr(0, 0, 0, 1, 0, 14, 16'h4010, 32'hdead_beec), 0, '0);
    add_row(make_instr(1, 0, 0, 1, 1, 8, 16'h0f00, 32'h0000_0010), 0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) drive_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    drain_accesses();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct <= (phase == 0) ? 31 : (phase == 1) ? 58 : 0;
      recv_idle_pct <= (phase == 0) ? 58 : (phase == 1) ? 31 : 0;
      for (int k = 0; k < 77; k++) drive_item(random_instr(), 0, '0);
      drain_accesses();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_block_transfer_address_sequencer: done, clean");
    end else begin
      $display("tb_block_transfer_address_sequencer: done, errors");
    end
    $finish;
  end

endmodule
